### hw/rtl/typed_key_value_record_store_defines.svh
// ----------------------------------------------------------------------------
// Typed key/value record store: assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TYPED_KEY_VALUE_RECORD_STORE_DEFINES_SVH
`define TYPED_KEY_VALUE_RECORD_STORE_DEFINES_SVH

// Check cons in the same cycle as ante
`define TKV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define TKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tkv_pkg.sv
// ----------------------------------------------------------------------------
// tkv_pkg
// Types, sizes and codes shared by the typed key/value record store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkv_pkg;

  // Table size and field sizes
  localparam int SLOTS      = 64;
  localparam int KEY_BYTES  = 8;
  localparam int DATA_BYTES = 8;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int FUNC_W     = 2;
  localparam int TYPE_W     = 3;
  localparam int KEY_W      = 64;
  localparam int DATA_W     = 64;
  localparam int STAT_W     = 2;

  // Byte masks for key and data words
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
      ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));
  localparam logic [DATA_W-1:0] DATA_MASK = (DATA_BYTES >= 8) ? {DATA_W{1'b1}} :
      ((DATA_W'(1) << (8 * DATA_BYTES)) - DATA_W'(1));

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

  // Record type codes
  localparam logic [TYPE_W-1:0] REC_STR  = 3'd0;
  localparam logic [TYPE_W-1:0] REC_U32  = 3'd1;
  localparam logic [TYPE_W-1:0] REC_S32  = 3'd2;
  localparam logic [TYPE_W-1:0] REC_F32  = 3'd3;
  localparam logic [TYPE_W-1:0] REC_FLAG = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_WPROT     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NO_MEM    = 2'd3;

  // Request item
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TYPE_W-1:0] data_type;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } in_t;

  // Result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [DATA_W-1:0] read_data;
  } out_t;

  // Classified request, front to back
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TYPE_W-1:0] data_type;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] dflt;
  } cmd_t;

  // One stored record
  typedef struct packed {
    logic [TYPE_W-1:0] data_type;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Back-end status
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] used_count;
  } bk_stat_t;

endpackage

`default_nettype wire

### hw/rtl/tkv_ram.sv
// ----------------------------------------------------------------------------
// tkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/tkv_front.sv
// ----------------------------------------------------------------------------
// tkv_front
// Accept requests, mask key and data words, and queue them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkv_front
  import tkv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire in_t  in_data,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_ready
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push_ok, pop_ok;
  cmd_t              cls;

  // Keep only the bytes the record type carries
  function automatic logic [DATA_W-1:0] shape_data(input logic [TYPE_W-1:0] t,
                                                   input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    case (t)
      REC_U32, REC_S32, REC_F32: begin
        r = v & {{(DATA_W-32){1'b0}}, 32'hFFFF_FFFF} & DATA_MASK;
      end
      REC_FLAG: begin
        r = {{(DATA_W-1){1'b0}}, |v[7:0]};
      end
      default: begin
        r = v & DATA_MASK;
      end
    endcase
    return r;
  endfunction

  // Classify the incoming request
  always_comb begin
    cls.func      = in_data.func;
    cls.data_type = in_data.data_type;
    cls.key       = in_data.key & KEY_MASK;
    cls.wr_data   = shape_data(in_data.data_type, in_data.value);
    cls.dflt      = in_data.value & DATA_MASK;
  end

  assign in_full   = (count_r == QCNT_W'(QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_ready && cmd_valid;

  // Store the transfer into the queue
  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tkv_back.sv
// ----------------------------------------------------------------------------
// tkv_back
// Search the record table one slot a cycle, then read, write or remove,
// and hold the result for the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkv_back
  import tkv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data,
  output bk_stat_t  stat
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              hit_r, hit_nxt;
  logic [DATA_W-1:0] hit_data_r, hit_data_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  out_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_item_r, out_item_nxt;
  logic              wp_r;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_wr_addr, ram_rd_addr;
  rec_t              ram_wr_rec;
  logic [REC_W-1:0]  ram_rd_q;
  rec_t              rd_rec;
  logic              rd_match, scan_last, out_free;
  logic [IDX_W-1:0]  last_idx;

  tkv_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_rec),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_q)
  );

  assign rd_rec    = rec_t'(ram_rd_q);
  assign rd_match  = (rd_rec.data_type == cmd_r.data_type) && (rd_rec.key == cmd_r.key);
  assign scan_last = ((CNT_W'(idx_r) + 1'b1) == used_r);
  assign last_idx  = IDX_W'(used_r - 1'b1);
  assign out_free  = !out_valid_r || out_pop;

  assign out_empty       = !out_valid_r;
  assign out_data        = out_item_r;
  assign stat.busy       = (state_r != S_IDLE);
  assign stat.used_count = used_r;

  // Sequence one request: search, act, hand over the result
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    hit_data_nxt  = hit_data_r;
    used_nxt      = used_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    cmd_ready     = 1'b0;
    ram_we        = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_rec    = '{data_type: cmd_r.data_type, key: cmd_r.key, data: cmd_r.wr_data};
    ram_rd_addr   = idx_r + 1'b1;

    case (state_r)
      S_IDLE: begin
        cmd_ready   = 1'b1;
        ram_rd_addr = '0;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          if (cmd.func == FUNC_NOP) begin
            res_nxt   = '{status: STAT_OK, found: 1'b0, read_data: '0};
            state_nxt = S_DONE;
          end else if ((cmd.func != FUNC_READ) && wp_r) begin
            res_nxt   = '{status: STAT_WPROT, found: 1'b0, read_data: '0};
            state_nxt = S_DONE;
          end else if (used_r == '0) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        // Data for slot idx_r arrives this cycle; slot idx_r + 1 is requested
        if (rd_match) begin
          hit_nxt      = 1'b1;
          hit_data_nxt = rd_rec.data;
          state_nxt    = S_EXEC;
        end else if (scan_last) begin
          state_nxt = S_EXEC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r.func)
          FUNC_READ: begin
            if (hit_r) begin
              res_nxt = '{status: STAT_OK, found: 1'b1, read_data: hit_data_r};
            end else begin
              res_nxt = '{status: STAT_NOT_FOUND, found: 1'b0, read_data: cmd_r.dflt};
            end
          end
          FUNC_WRITE: begin
            if (hit_r) begin
              ram_we  = 1'b1;
              res_nxt = '{status: STAT_OK, found: 1'b1, read_data: '0};
            end else if (used_r == CNT_W'(SLOTS)) begin
              res_nxt = '{status: STAT_NO_MEM, found: 1'b0, read_data: '0};
            end else begin
              ram_we      = 1'b1;
              ram_wr_addr = IDX_W'(used_r);
              used_nxt    = used_r + 1'b1;
              res_nxt     = '{status: STAT_OK, found: 1'b0, read_data: '0};
            end
          end
          FUNC_REMOVE: begin
            if (!hit_r) begin
              res_nxt = '{status: STAT_NOT_FOUND, found: 1'b0, read_data: '0};
            end else begin
              res_nxt = '{status: STAT_OK, found: 1'b1, read_data: '0};
              if (idx_r == last_idx) begin
                used_nxt = used_r - 1'b1;
              end else begin
                // Fetch the last record to fill the hole
                ram_rd_addr = last_idx;
                state_nxt   = S_MOVE;
              end
            end
          end
          default: begin
            res_nxt = '{status: STAT_OK, found: 1'b0, read_data: '0};
          end
        endcase
      end

      S_MOVE: begin
        ram_we     = 1'b1;
        ram_wr_rec = rd_rec;
        used_nxt   = used_r - 1'b1;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      wp_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        wp_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    hit_r      <= hit_nxt;
    hit_data_r <= hit_data_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/typed_key_value_record_store.sv
// ----------------------------------------------------------------------------
// typed_key_value_record_store
// Table of up to SLOTS typed records (type, key, data) with read, write and
// remove requests, matched by linear search on type and key.
//
// Request channel: drive in_data and raise in_push; a transfer happens at a
// clock edge with in_push high and in_full low. Up to two requests queue.
// Result channel: while out_empty is low, out_data holds the oldest result;
// it transfers at an edge with out_pop high. One result per request, in order.
// cfg_wr_en with cfg_wr_data sets write protect; write it only when idle.
// A request passes through the back end in steps: it is taken, the table is
// searched with one slot compare per cycle through the single read port of
// the record RAM, the request is acted on and the result is handed over.
// A hit ends the search early; a remove that moves the last record adds a
// move step but always hits before the last slot. Requests run one at a time.
// Reset empties the table and clears write protect; rst_n is synchronous.
// A stalled result channel holds the finished result while the next request
// is searched; the queue fills and in_full rises after that.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "typed_key_value_record_store_defines.svh"

module typed_key_value_record_store
  import tkv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire in_t  in_data,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_ready;
  bk_stat_t         stat;
  logic [CNT_W-1:0] used_cnt;

  // Request intake and classification
  tkv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // Table search and update
  tkv_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .stat        (stat)
  );

  assign used_cnt = stat.used_count;

  // Fill count stays within the table
  `TKV_ASSERT_NOW(a_used_range, 1'b1, used_cnt <= CNT_W'(SLOTS), "used count above SLOTS")

  // Fill count moves by at most one record per cycle
  `TKV_ASSERT_NEXT(a_used_step, 1'b1, CNT_W'(used_cnt - $past(used_cnt) + 1'b1) <= CNT_W'(2), "bad used step")

  // An idle back end leaves the fill count alone
  `TKV_ASSERT_NEXT(a_idle_hold, !stat.busy, $stable(used_cnt), "used count changed while idle")

endmodule

`default_nettype wire
